[sv/gpio_port_register_block_defines.svh]
// Assertion macros used by the GPIO port register block controller.
`ifndef GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, checked on clk, held off during rst.
`define GPRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, held off during rst.
`define GPRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/gprb_pkg.sv]
// Shared types and constants of the GPIO port register block.
package gprb_pkg;

  localparam int DATA_W = 32;
  localparam int PIN_W  = 16;
  localparam int PORT_W = 4;
  localparam int OFF_W  = 4;

  // Word offsets of the per-port registers
  typedef enum logic [OFF_W-1:0] {
    OFF_MODE  = 4'd0,
    OFF_TYPE  = 4'd1,
    OFF_SPEED = 4'd2,
    OFF_PULL  = 4'd3,
    OFF_IN    = 4'd4,
    OFF_OUT   = 4'd5,
    OFF_SETRST = 4'd6,
    OFF_LOCK  = 4'd7,
    OFF_AFL   = 4'd8,
    OFF_AFH   = 4'd9
  } offset_t;

  // Progress through the lock key sequence
  typedef enum logic [1:0] {
    KEY_IDLE  = 2'd0,
    KEY_ONE   = 2'd1,
    KEY_ZERO  = 2'd2,
    KEY_ARMED = 2'd3
  } key_phase_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // read-modify-write the addressed port, latch the result
  } gprb_cmd_t;

endpackage

[sv/gprb_ctrl.sv]
// Controller of the GPIO port register block: sequences capture, execute and delivery.
`include "gpio_port_register_block_defines.svh"

module gprb_ctrl
  import gprb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output gprb_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // handshake and commands
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state == S_EXEC);

  `GPRB_ASSERT_NOW(a_one_side, in_ready, !out_valid, "input and output open together")
  `GPRB_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "captured beat not executed")
  `GPRB_ASSERT_NEXT(a_exec_out, cmd.exec, out_valid, "executed beat not presented")
  `GPRB_ASSERT_NEXT(a_out_idle, out_valid && out_ready, in_ready, "no return to idle")

endmodule

[sv/gprb_datapath.sv]
// Datapath of the GPIO port register block: input capture, port registers, result register.
module gprb_datapath
  import gprb_pkg::*;
#(
  parameter int PORTS = 8,
  parameter int PINS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gprb_cmd_t         cmd,
  input  logic              func,
  input  logic [PORT_W-1:0] port,
  input  logic [OFF_W-1:0]  offset,
  input  logic [DATA_W-1:0] write_data,
  input  logic [PIN_W-1:0]  pin_levels,
  output logic [DATA_W-1:0] read_data,
  output logic              access_error,
  output logic [PIN_W-1:0]  output_levels
);

  localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'((33'd1 << PINS) - 33'd1);

  // each pin bit widened to a 2-bit field
  function automatic logic [DATA_W-1:0] spread2(input logic [PIN_W-1:0] m);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < PIN_W; i++) r[2*i +: 2] = {2{m[i]}};
    return r;
  endfunction

  // eight pin bits widened to 4-bit fields
  function automatic logic [DATA_W-1:0] spread4(input logic [7:0] m);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) r[4*i +: 4] = {4{m[i]}};
    return r;
  endfunction

  // captured beat
  logic              func_q;
  logic [PORT_W-1:0] port_q;
  logic [OFF_W-1:0]  offset_q;
  logic [DATA_W-1:0] wdata_q;
  logic [PIN_W-1:0]  levels_q;

  // per-port registers
  logic [DATA_W-1:0] mode_bits       [PORTS];
  logic [PIN_W-1:0]  open_drain_bits [PORTS];
  logic [DATA_W-1:0] speed_bits      [PORTS];
  logic [DATA_W-1:0] pull_bits       [PORTS];
  logic [PIN_W-1:0]  out_data        [PORTS];
  logic [DATA_W-1:0] alt_func_low    [PORTS];
  logic [DATA_W-1:0] alt_func_high   [PORTS];
  logic [PIN_W-1:0]  lock_pins       [PORTS];
  logic              lock_active     [PORTS];
  key_phase_t        key_phase       [PORTS];

  // next values for the addressed port
  logic [DATA_W-1:0] mode_next, speed_next, pull_next, afl_next, afh_next;
  logic [PIN_W-1:0]  od_next, out_next, lock_pins_next;
  logic              lock_active_next;
  key_phase_t        key_phase_next;

  logic [PIDX_W-1:0] idx;
  logic              port_ok, off_ok, hit;
  logic [PIN_W-1:0]  allow, new_pins;
  logic              key, same;
  logic [DATA_W-1:0] rd;
  logic [PIN_W-1:0]  outl;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      port_q   <= port;
      offset_q <= offset;
      wdata_q  <= write_data;
      levels_q <= pin_levels & PIN_MASK;
    end
  end

  // decode and read-modify-write of the addressed port
  always_comb begin
    idx      = port_q[PIDX_W-1:0];
    port_ok  = ({1'b0, port_q} < 5'(PORTS));
    off_ok   = (offset_q <= OFF_AFH);
    hit      = port_ok && off_ok;
    allow    = PIN_MASK & ~(lock_active[idx] ? lock_pins[idx] : '0);
    new_pins = wdata_q[PIN_W-1:0] & PIN_MASK;
    key      = wdata_q[PIN_W];
    same     = (new_pins == lock_pins[idx]);

    mode_next        = mode_bits[idx];
    od_next          = open_drain_bits[idx];
    speed_next       = speed_bits[idx];
    pull_next        = pull_bits[idx];
    out_next         = out_data[idx];
    afl_next         = alt_func_low[idx];
    afh_next         = alt_func_high[idx];
    lock_pins_next   = lock_pins[idx];
    lock_active_next = lock_active[idx];
    key_phase_next   = key_phase[idx];
    rd               = '0;

    if (hit && !func_q) begin
      unique case (offset_t'(offset_q))
        OFF_MODE:   rd = mode_bits[idx];
        OFF_TYPE:   rd = DATA_W'(open_drain_bits[idx]);
        OFF_SPEED:  rd = speed_bits[idx];
        OFF_PULL:   rd = pull_bits[idx];
        OFF_IN:     rd = DATA_W'(levels_q);
        OFF_OUT:    rd = DATA_W'(out_data[idx]);
        OFF_SETRST: rd = '0;
        OFF_LOCK: begin
          rd = {15'd0, lock_active[idx], lock_pins[idx]};
          // read closing the key sequence engages the lock
          if (key_phase[idx] == KEY_ARMED) begin
            lock_active_next = 1'b1;
            key_phase_next   = KEY_IDLE;
          end
        end
        OFF_AFL:    rd = alt_func_low[idx];
        OFF_AFH:    rd = alt_func_high[idx];
        default:    rd = '0;
      endcase
    end else if (hit) begin
      unique case (offset_t'(offset_q))
        OFF_MODE:   mode_next  = (mode_next & ~spread2(allow)) | (wdata_q & spread2(allow));
        OFF_TYPE:   od_next    = (od_next & ~allow) | (wdata_q[PIN_W-1:0] & allow);
        OFF_SPEED:  speed_next = (speed_next & ~spread2(allow)) | (wdata_q & spread2(allow));
        OFF_PULL:   pull_next  = (pull_next & ~spread2(allow)) | (wdata_q & spread2(allow));
        OFF_IN:     ;
        OFF_OUT:    out_next = new_pins;
        OFF_SETRST: begin
          // set beats reset on the same pin
          out_next = ((out_next & ~wdata_q[DATA_W-1:PIN_W]) | wdata_q[PIN_W-1:0]) & PIN_MASK;
        end
        OFF_LOCK: begin
          if (!lock_active[idx]) begin
            lock_pins_next = new_pins;
            if (!key && key_phase[idx] == KEY_ONE && same) begin
              key_phase_next = KEY_ZERO;
            end else if (key && key_phase[idx] == KEY_ZERO && same) begin
              key_phase_next = KEY_ARMED;
            end else begin
              key_phase_next = key ? KEY_ONE : KEY_IDLE;
            end
          end
        end
        OFF_AFL: afl_next = (afl_next & ~spread4(allow[7:0])) | (wdata_q & spread4(allow[7:0]));
        OFF_AFH: afh_next = (afh_next & ~spread4(allow[15:8])) | (wdata_q & spread4(allow[15:8]));
        default: ;
      endcase
    end

    outl = port_ok ? out_next : '0;
  end

  // port register update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PORTS; p++) begin
        mode_bits[p]       <= '0;
        open_drain_bits[p] <= '0;
        speed_bits[p]      <= '0;
        pull_bits[p]       <= '0;
        out_data[p]        <= '0;
        alt_func_low[p]    <= '0;
        alt_func_high[p]   <= '0;
        lock_pins[p]       <= '0;
        lock_active[p]     <= 1'b0;
        key_phase[p]       <= KEY_IDLE;
      end
    end else if (cmd.exec && hit) begin
      mode_bits[idx]       <= mode_next;
      open_drain_bits[idx] <= od_next;
      speed_bits[idx]      <= speed_next;
      pull_bits[idx]       <= pull_next;
      out_data[idx]        <= out_next;
      alt_func_low[idx]    <= afl_next;
      alt_func_high[idx]   <= afh_next;
      lock_pins[idx]       <= lock_pins_next;
      lock_active[idx]     <= lock_active_next;
      key_phase[idx]       <= key_phase_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data     <= rd;
      access_error  <= !hit;
      output_levels <= outl;
    end
  end

endmodule

[sv/gpio_port_register_block.sv]
// Top level of the GPIO port register block.
// Register block for PORTS GPIO ports of PINS pins each. Every input beat is one bus
// access (read or write of one word register of one port, with the sampled pin levels)
// and yields one result beat: read data (zero on writes and errors), an error flag for
// a port at or above PORTS or an offset above 9, and the port's output data after the
// access. A beat accepted in the idle state has its read-modify-write of the addressed
// port's registers in the following cycle, and its result is registered at the end of
// that cycle and offered until taken; the next beat is accepted in the cycle after the
// result is taken, so a new access is not accepted before the last result is taken.
// The controller steps through capture, execute and delivery. All port registers
// clear at reset; a completed lock key sequence (writes with key 1, 0, 1 and equal
// pin bits, then a lock read) freezes the configuration of the chosen pins until the
// next reset.
module gpio_port_register_block
  import gprb_pkg::*;
#(
  parameter int PORTS = 8,
  parameter int PINS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [PORT_W-1:0] port,
  input  logic [OFF_W-1:0]  offset,
  input  logic [DATA_W-1:0] write_data,
  input  logic [PIN_W-1:0]  pin_levels,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic              access_error,
  output logic [PIN_W-1:0]  output_levels
);

  gprb_cmd_t cmd;

  // sequencer
  gprb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // port registers and result
  gprb_datapath #(
    .PORTS (PORTS),
    .PINS  (PINS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .port          (port),
    .offset        (offset),
    .write_data    (write_data),
    .pin_levels    (pin_levels),
    .read_data     (read_data),
    .access_error  (access_error),
    .output_levels (output_levels)
  );

endmodule
